// ===== design/swrvs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swrvs_pkg;

    localparam int SINE_TABLE_ENTRIES = 256;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    localparam int COORD_W = 32;
    localparam int FREQ_W  = 24;
    localparam int TIME_W  = 32;
    localparam int AMP_W   = 18;
    localparam int SIN_W   = 18;
    localparam int SCALE_W = 19;
    localparam int CFG_W   = 32;
    localparam int DATA_W  = 3 * COORD_W;

    typedef enum logic [1:0] {
        REG_FREQ  = 2'd0,
        REG_SPEED = 2'd1,
        REG_TIME  = 2'd2,
        REG_AMP   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic ld_mul;
        logic ld_phase;
        logic ld_sine;
        logic ld_amp;
        logic ld_scale;
        logic ld_coord;
        logic ld_out;
    } stage_en_t;

    typedef struct packed {
        logic        last;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } vertex_t;

    // Taylor series through x^11 in Q30, rounded to Q16 and clamped to one
    function automatic logic [16:0] sine_from_x(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] e;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        e  = (s + 64'd8192) >> 14;
        if (e > 64'd65536)
        begin
            e = 64'd65536;
        end
        return e[16:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/swrvs_phase.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swrvs_phase #(
    parameter int SINE_ENTRIES = swrvs_pkg::SINE_TABLE_ENTRIES,
    parameter int IDX_W        = $clog2(SINE_ENTRIES + 1)
) (
    input  wire logic                         clk,
    input  wire swrvs_pkg::stage_en_t         en,
    input  wire logic [31:0]                  pos_y,
    input  wire logic [swrvs_pkg::FREQ_W-1:0] spatial_frequency,
    input  wire logic [swrvs_pkg::FREQ_W-1:0] phase_rate,
    input  wire logic [swrvs_pkg::TIME_W-1:0] frame_time,
    output logic [IDX_W-1:0]                  tab_idx,
    output logic                              negate
);

    logic [31:0]       freq_ext;
    logic [31:0]       speed_ext;
    logic [31:0]       prod_y_full;
    logic [31:0]       prod_t_full;
    logic [31:0]       prod_y_reg;
    logic [31:0]       prod_t_reg;
    logic [31:0]       sum;
    logic [13:0]       frac;
    logic [1:0]        quad;
    logic [IDX_W+13:0] frac_scaled;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  idx_next;
    logic [IDX_W-1:0]  idx_reg;
    logic              negate_reg;

    assign freq_ext    = {{(32 - swrvs_pkg::FREQ_W){spatial_frequency[swrvs_pkg::FREQ_W-1]}},
                          spatial_frequency};
    assign speed_ext   = {{(32 - swrvs_pkg::FREQ_W){phase_rate[swrvs_pkg::FREQ_W-1]}},
                          phase_rate};
    assign prod_y_full = pos_y * freq_ext;
    assign prod_t_full = frame_time * speed_ext;

    always_ff @(posedge clk)
    begin
        if (en.ld_mul)
        begin
            prod_y_reg <= prod_y_full;
            prod_t_reg <= prod_t_full;
        end
    end

    // Phase in turns: bits 31:30 quadrant, bits 29:16 position inside it
    assign sum         = prod_y_reg + prod_t_reg;
    assign quad        = sum[31:30];
    assign frac        = sum[29:16];
    assign frac_scaled = (IDX_W + 14)'(frac) * (IDX_W + 14)'(SINE_ENTRIES);
    assign idx         = frac_scaled[IDX_W+13:14];
    assign idx_next    = quad[0] ? (IDX_W'(SINE_ENTRIES) - idx) : idx;

    always_ff @(posedge clk)
    begin
        if (en.ld_phase)
        begin
            idx_reg    <= idx_next;
            negate_reg <= quad[1];
        end
    end

    assign tab_idx = idx_reg;
    assign negate  = negate_reg;

endmodule

`default_nettype wire

// ===== design/swrvs_sine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swrvs_sine #(
    parameter int SINE_ENTRIES = swrvs_pkg::SINE_TABLE_ENTRIES,
    parameter int IDX_W        = $clog2(SINE_ENTRIES + 1)
) (
    input  wire logic                               clk,
    input  wire swrvs_pkg::stage_en_t               en,
    input  wire logic [IDX_W-1:0]                   tab_idx,
    input  wire logic                               negate,
    output logic signed [swrvs_pkg::SIN_W-1:0]      sine
);

    logic [16:0]                              tab [0:SINE_ENTRIES];
    logic signed [swrvs_pkg::SIN_W-1:0]       mag;
    logic signed [swrvs_pkg::SIN_W-1:0]       sine_next;
    logic signed [swrvs_pkg::SIN_W-1:0]       sine_reg;

    for (genvar i = 0; i <= SINE_ENTRIES; i++)
    begin : g_tab
        localparam logic [63:0] XQ = (swrvs_pkg::HALF_PI_Q30 * 64'(i)) / SINE_ENTRIES;
        assign tab[i] = swrvs_pkg::sine_from_x(XQ);
    end

    assign mag       = signed'({1'b0, tab[tab_idx]});
    assign sine_next = negate ? -mag : mag;

    always_ff @(posedge clk)
    begin
        if (en.ld_sine)
        begin
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule

`default_nettype wire

// ===== design/swrvs_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swrvs_scale (
    input  wire logic                                 clk,
    input  wire swrvs_pkg::stage_en_t                 en,
    input  wire logic signed [swrvs_pkg::SIN_W-1:0]   sine,
    input  wire logic [swrvs_pkg::AMP_W-1:0]          wave_amplitude,
    output logic signed [swrvs_pkg::SCALE_W-1:0]      scale
);

    localparam int PROD_W = swrvs_pkg::AMP_W + swrvs_pkg::SIN_W;

    logic signed [PROD_W-1:0]             prod_next;
    logic signed [PROD_W-1:0]             prod_reg;
    logic signed [PROD_W-17:0]            prod_floor;
    logic signed [PROD_W-17:0]            scale_wide;
    logic signed [swrvs_pkg::SCALE_W-1:0] scale_reg;

    assign prod_next = PROD_W'(signed'(wave_amplitude)) * PROD_W'(sine);

    always_ff @(posedge clk)
    begin
        if (en.ld_amp)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod_floor = prod_reg[PROD_W-1:16];
    assign scale_wide = prod_floor + (PROD_W - 16)'(65536);

    always_ff @(posedge clk)
    begin
        if (en.ld_scale)
        begin
            scale_reg <= scale_wide[swrvs_pkg::SCALE_W-1:0];
        end
    end

    assign scale = scale_reg;

endmodule

`default_nettype wire

// ===== design/swrvs_apply.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swrvs_apply (
    input  wire logic                                  clk,
    input  wire swrvs_pkg::stage_en_t                  en,
    input  wire logic signed [swrvs_pkg::SCALE_W-1:0]  scale,
    input  wire logic [31:0]                           pos_x,
    input  wire logic [31:0]                           pos_z,
    output logic [31:0]                                out_x,
    output logic [31:0]                                out_z
);

    localparam int PROD_W = 32 + swrvs_pkg::SCALE_W;

    logic signed [PROD_W-1:0] px_next;
    logic signed [PROD_W-1:0] pz_next;
    logic signed [PROD_W-1:0] px_reg;
    logic signed [PROD_W-1:0] pz_reg;
    logic [31:0]              ox_next;
    logic [31:0]              oz_next;
    logic [31:0]              ox_reg;
    logic [31:0]              oz_reg;

    function automatic logic [31:0] sat_shift(input logic [PROD_W-1:0] p);
        logic fits;
        fits = (p[PROD_W-1:47] == {(PROD_W - 47){p[47]}});
        if (fits)
        begin
            return p[47:16];
        end
        return p[PROD_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    assign px_next = PROD_W'(signed'(pos_x)) * PROD_W'(scale);
    assign pz_next = PROD_W'(signed'(pos_z)) * PROD_W'(scale);

    always_ff @(posedge clk)
    begin
        if (en.ld_coord)
        begin
            px_reg <= px_next;
            pz_reg <= pz_next;
        end
    end

    assign ox_next = sat_shift(px_reg);
    assign oz_next = sat_shift(pz_reg);

    always_ff @(posedge clk)
    begin
        if (en.ld_out)
        begin
            ox_reg <= ox_next;
            oz_reg <= oz_next;
        end
    end

    assign out_x = ox_reg;
    assign out_z = oz_reg;

endmodule

`default_nettype wire

// ===== design/sine_wave_radial_vertex_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake          Payload
// s_*      in         s_tvalid/s_tready  s_tdata {pos_z, pos_y, pos_x}, s_tlast last_in
// m_*      out        m_tvalid/m_tready  m_tdata {out_z, out_y, out_x}, m_tlast last_out
// cfg_*    in         cfg_we             cfg_addr register index, cfg_wdata value
//
// Seven register stages: phase products, phase sum and table index, sine lookup,
// amplitude product, scale, coordinate products, shift and saturate.
// One request per cycle while the output is not stalled. rst_n clears the stage valid
// bits and the speed, time and amplitude registers, and resets frequency to 65536.
// A stage loads when it is empty or the stage after it moves; a stalled output
// holds the pipeline back while any empty stage still takes a new request.

module sine_wave_radial_vertex_scale #(
    parameter int SINE_ENTRIES = swrvs_pkg::SINE_TABLE_ENTRIES
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [swrvs_pkg::DATA_W-1:0] s_tdata,   // pos_x, pos_y, pos_z
    input  wire logic                         s_tlast,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [swrvs_pkg::DATA_W-1:0]      m_tdata,   // out_x, out_y, out_z
    output logic                              m_tlast,
    input  wire logic                         cfg_we,
    input  wire logic [1:0]                   cfg_addr,
    input  wire logic [swrvs_pkg::CFG_W-1:0]  cfg_wdata
);

    localparam int STAGES = 7;
    localparam int IDX_W  = $clog2(SINE_ENTRIES + 1);

    logic [swrvs_pkg::FREQ_W-1:0]       freq_reg;
    logic [swrvs_pkg::FREQ_W-1:0]       speed_reg;
    logic [swrvs_pkg::TIME_W-1:0]       time_reg;
    logic [swrvs_pkg::AMP_W-1:0]        amp_reg;

    logic [STAGES:1]                    valid_reg;
    logic [STAGES+1:1]                  adv;
    swrvs_pkg::stage_en_t               en;
    swrvs_pkg::vertex_t                 vtx_in;
    swrvs_pkg::vertex_t                 vtx_reg [1:STAGES];

    logic [IDX_W-1:0]                   tab_idx;
    logic                               negate;
    logic signed [swrvs_pkg::SIN_W-1:0] sine;
    logic signed [swrvs_pkg::SCALE_W-1:0] scale;
    logic [31:0]                        out_x;
    logic [31:0]                        out_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg  <= swrvs_pkg::FREQ_W'(65536);
            speed_reg <= '0;
            time_reg  <= '0;
            amp_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (swrvs_pkg::cfg_idx_t'(cfg_addr))
                swrvs_pkg::REG_FREQ:  freq_reg  <= cfg_wdata[swrvs_pkg::FREQ_W-1:0];
                swrvs_pkg::REG_SPEED: speed_reg <= cfg_wdata[swrvs_pkg::FREQ_W-1:0];
                swrvs_pkg::REG_TIME:  time_reg  <= cfg_wdata[swrvs_pkg::TIME_W-1:0];
                swrvs_pkg::REG_AMP:   amp_reg   <= cfg_wdata[swrvs_pkg::AMP_W-1:0];
                default:              freq_reg  <= freq_reg;
            endcase
        end
    end

    // Advance a stage when it is empty or the next one advances
    always_comb
    begin
        adv[STAGES+1] = m_tready;
        for (int k = STAGES; k >= 1; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign en.ld_mul   = adv[1];
    assign en.ld_phase = adv[2];
    assign en.ld_sine  = adv[3];
    assign en.ld_amp   = adv[4];
    assign en.ld_scale = adv[5];
    assign en.ld_coord = adv[6];
    assign en.ld_out   = adv[7];

    assign s_tready = adv[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                valid_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign vtx_in.x    = s_tdata[31:0];
    assign vtx_in.y    = s_tdata[63:32];
    assign vtx_in.z    = s_tdata[95:64];
    assign vtx_in.last = s_tlast;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            vtx_reg[1] <= vtx_in;
        end
        for (int k = 2; k <= STAGES; k++)
        begin
            if (adv[k])
            begin
                vtx_reg[k] <= vtx_reg[k-1];
            end
        end
    end

    swrvs_phase #(
        .SINE_ENTRIES (SINE_ENTRIES),
        .IDX_W        (IDX_W)
    ) u_phase (
        .clk               (clk),
        .en                (en),
        .pos_y             (vtx_in.y),
        .spatial_frequency (freq_reg),
        .phase_rate        (speed_reg),
        .frame_time        (time_reg),
        .tab_idx           (tab_idx),
        .negate            (negate)
    );

    swrvs_sine #(
        .SINE_ENTRIES (SINE_ENTRIES),
        .IDX_W        (IDX_W)
    ) u_sine (
        .clk     (clk),
        .en      (en),
        .tab_idx (tab_idx),
        .negate  (negate),
        .sine    (sine)
    );

    swrvs_scale u_scale (
        .clk            (clk),
        .en             (en),
        .sine           (sine),
        .wave_amplitude (amp_reg),
        .scale          (scale)
    );

    swrvs_apply u_apply (
        .clk   (clk),
        .en    (en),
        .scale (scale),
        .pos_x (vtx_reg[5].x),
        .pos_z (vtx_reg[5].z),
        .out_x (out_x),
        .out_z (out_z)
    );

    assign m_tvalid = valid_reg[STAGES];
    assign m_tdata  = {out_z, vtx_reg[STAGES].y, out_x};
    assign m_tlast  = vtx_reg[STAGES].last;

endmodule

`default_nettype wire

// ===== sim/sine_wave_radial_vertex_scale_test.sv =====
`timescale 1ns / 1ps

module sine_wave_radial_vertex_scale_test;

    import swrvs_pkg::*;

    class vertex_scoreboard;

        logic [16:0]        sine_rom [0:SINE_TABLE_ENTRIES];
        logic signed [23:0] freq_q;
        logic signed [23:0] speed_q;
        logic [31:0]        ftime_q;
        logic signed [17:0] amp_q;
        vertex_t            scaled_q [$];
        int                 errors;

        function new();
            freq_q  = 24'sd65536;
            speed_q = '0;
            ftime_q = '0;
            amp_q   = '0;
            errors  = 0;
            build_sine_rom();
        endfunction

        // Quarter-wave sine in Q1.16 from a Q30 Taylor series through x^11
        function void build_sine_rom();
            longint unsigned divs [0:4];
            longint unsigned ang;
            longint unsigned sq;
            longint unsigned acc;
            longint unsigned s;
            longint unsigned e;
            divs[0] = 110;
            divs[1] = 72;
            divs[2] = 42;
            divs[3] = 20;
            divs[4] = 6;
            for (longint unsigned i = 0; i <= SINE_TABLE_ENTRIES; i++)
            begin
                ang = (HALF_PI_Q30 * i) / SINE_TABLE_ENTRIES;
                sq  = (ang * ang) >> 30;
                acc = ONE_Q30;
                for (int k = 0; k < 5; k++)
                begin
                    acc = ONE_Q30 - ((sq * acc) >> 30) / divs[k];
                end
                s = (ang * acc) >> 30;
                e = (s + 8192) >> 14;
                if (e > 65536)
                begin
                    e = 65536;
                end
                sine_rom[i] = e[16:0];
            end
        endfunction

        function void set_reg(cfg_idx_t idx, logic [31:0] val);
            case (idx)
                REG_FREQ:  freq_q  = val[23:0];
                REG_SPEED: speed_q = val[23:0];
                REG_TIME:  ftime_q = val;
                REG_AMP:   amp_q   = val[17:0];
                default:   ;
            endcase
        endfunction

        function logic [31:0] clamp32(longint v);
            if (v > 64'sh7FFF_FFFF)
            begin
                return 32'h7FFF_FFFF;
            end
            if (v < -64'sh8000_0000)
            begin
                return 32'h8000_0000;
            end
            return v[31:0];
        endfunction

        function vertex_t scale_vertex(vertex_t v);
            vertex_t         r;
            longint          phase_sum;
            logic [15:0]     ph;
            logic [1:0]      quad;
            longint unsigned idx;
            longint unsigned j;
            longint          sn;
            longint          scl;
            phase_sum = longint'($signed(v.y)) * longint'(freq_q)
                      + longint'({32'b0, ftime_q}) * longint'(speed_q);
            ph   = phase_sum[31:16];
            quad = ph[15:14];
            idx  = ({50'd0, ph[13:0]} * SINE_TABLE_ENTRIES) >> 14;
            j    = quad[0] ? SINE_TABLE_ENTRIES - idx : idx;
            if (j > SINE_TABLE_ENTRIES)
            begin
                j = SINE_TABLE_ENTRIES;
            end
            sn = longint'({47'd0, sine_rom[j]});
            if (quad[1])
            begin
                sn = -sn;
            end
            scl    = 64'sd65536 + ((longint'(amp_q) * sn) >>> 16);
            r.x    = clamp32((longint'($signed(v.x)) * scl) >>> 16);
            r.y    = v.y;
            r.z    = clamp32((longint'($signed(v.z)) * scl) >>> 16);
            r.last = v.last;
            return r;
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        function void note_vertex(vertex_t v);
            scaled_q.push_back(scale_vertex(v));
        endfunction

        task check_vertex(logic [DATA_W-1:0] d, logic last);
            vertex_t want;
            if (scaled_q.size() == 0)
            begin
                report($sformatf("unexpected output %h last %b", d, last));
                return;
            end
            want = scaled_q.pop_front();
            if (d[31:0] !== want.x)
            begin
                report($sformatf("out_x %h, want %h", d[31:0], want.x));
            end
            if (d[63:32] !== want.y)
            begin
                report($sformatf("out_y %h, want %h", d[63:32], want.y));
            end
            if (d[95:64] !== want.z)
            begin
                report($sformatf("out_z %h, want %h", d[95:64], want.z));
            end
            if (last !== want.last)
            begin
                report($sformatf("last_out %b, want %b", last, want.last));
            end
        endtask

        function int pending();
            return scaled_q.size();
        endfunction

    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;    // pos_x, pos_y, pos_z
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;    // out_x, out_y, out_z
    logic              m_tlast;
    logic              cfg_we;
    logic [1:0]        cfg_addr;
    logic [CFG_W-1:0]  cfg_wdata;

    vertex_scoreboard sb;
    bit               gaps_on;
    int               rx_hold_cycles;

    sine_wave_radial_vertex_scale DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic vertex_t make_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                            logic last);
        vertex_t v;
        v.x    = x;
        v.y    = y;
        v.z    = z;
        v.last = last;
        return v;
    endfunction

    function automatic logic [31:0] edge_word();
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'h0000_0001;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] coord_word();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return int'($urandom_range(0, 524288)) - 262144;
            2:       return edge_word();
            default: return int'($urandom_range(0, 1 << 26)) - (1 << 25);
        endcase
    endfunction

    function automatic vertex_t random_vertex();
        return make_vertex(coord_word(), $urandom, coord_word(), $urandom_range(0, 7) == 0);
    endfunction

    task automatic send_vertex(input vertex_t v);
        int gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {v.z, v.y, v.x};
        s_tlast  <= v.last;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sb.note_vertex(v);
    endtask

    task automatic end_burst();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    // Junk above each register width must be dropped by the block
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        logic [31:0] keep;
        logic [31:0] word;
        case (idx)
            REG_FREQ, REG_SPEED: keep = 32'h00FF_FFFF;
            REG_AMP:             keep = 32'h0003_FFFF;
            default:             keep = 32'hFFFF_FFFF;
        endcase
        word = (val & keep) | ($urandom & ~keep);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= word;
        @(posedge clk);
        sb.set_reg(idx, word);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] freq, input logic [31:0] speed,
                             input logic [31:0] ftime, input logic [31:0] amp);
        write_reg(REG_FREQ, freq);
        write_reg(REG_SPEED, speed);
        write_reg(REG_TIME, ftime);
        write_reg(REG_AMP, amp);
    endtask

    task automatic run_random(input int n, input bit hold, input bit pause);
        for (int i = 0; i < n; i++)
        begin
            if (hold && i == 0)
            begin
                rx_hold_cycles = 60;
            end
            if (pause && i == n / 2)
            begin
                end_burst();
                wait_drained();
            end
            send_vertex(random_vertex());
        end
        end_burst();
        wait_drained();
    endtask

    // Receiver: random backpressure plus an occasional long hold
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(negedge clk);
                rx_hold_cycles = 0;
            end
            gap = gaps_on ? $urandom_range(0, 3) : 0;
            repeat (gap)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!m_tvalid);
            sb.check_vertex(m_tdata, m_tlast);
        end
    end

    initial
    begin
        logic [15:0] ph_pts [0:7];
        sb             = new();
        gaps_on        = 1'b1;
        rx_hold_cycles = 0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = REG_FREQ;
        cfg_wdata      = '0;
        ph_pts = '{16'h0000, 16'h2000, 16'h4000, 16'h6000,
                   16'h8000, 16'hA000, 16'hC000, 16'hFFFF};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: unit scale, coordinate extremes pass through
        send_vertex(make_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1));
        send_vertex(make_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
        send_vertex(make_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0));
        end_burst();
        wait_drained();

        // One turn per unit height: y[15:0] is the phase, walk the quadrants
        configure(32'd65536, 32'd0, 32'd0, 32'd131071);
        for (int i = 0; i < 8; i++)
        begin
            send_vertex(make_vertex(32'h0001_0000, {16'h0000, ph_pts[i]}, 32'hFFFF_0000,
                                    i[0]));
        end
        send_vertex(make_vertex(32'h7FFF_FFFF, 32'h0000_4000, 32'h8000_0000, 1'b1));
        send_vertex(make_vertex(32'h8000_0000, 32'h0000_4000, 32'h7FFF_FFFF, 1'b0));
        end_burst();
        wait_drained();

        // Negative amplitude mirrors, extreme frequency, speed and time
        configure(32'hFF80_0000, 32'h007F_FFFF, 32'hFFFF_FFFF, 32'h0002_0000);
        send_vertex(make_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        send_vertex(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        send_vertex(make_vertex(32'h0001_0000, 32'h0000_4000, 32'hFFFF_0000, 1'b0));
        send_vertex(make_vertex(32'h0001_0000, 32'h0000_C000, 32'hFFFF_0000, 1'b0));
        send_vertex(make_vertex(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 1'b1));
        end_burst();
        wait_drained();

        for (int ph = 0; ph < 7; ph++)
        begin
            gaps_on = (ph != 1);
            case (ph)
                0: configure(32'd65536, 32'd0, 32'd0, 32'd32768);
                1: configure(32'h007F_FFFF, 32'hFF80_0000, $urandom, 32'd131071);
                2: configure($urandom, $urandom, $urandom, $urandom);
                3: configure(32'hFF80_0000, 32'h007F_FFFF, 32'hFFFF_FFFF, 32'h0002_0000);
                4: configure($urandom, $urandom, $urandom, 32'd65536);
                5: configure(32'd0, $urandom, $urandom, $urandom);
                default: configure($urandom, $urandom, $urandom, $urandom);
            endcase
            run_random(200, ph == 0 || ph == 6, ph == 2);
        end

        gaps_on = 1'b1;
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/swrvs_pkg.sv
design/swrvs_phase.sv
design/swrvs_sine.sv
design/swrvs_scale.sv
design/swrvs_apply.sv
design/sine_wave_radial_vertex_scale.sv
sim/sine_wave_radial_vertex_scale_test.sv
